// File: rtl/drbg_pkg.sv
// Shared types and constants for the daily request budget guard.
// Holds item/result layouts, code enums and the day-divider constants.
// No dependencies.
package drbg_pkg;

  localparam int InDataW  = 96;
  localparam int OutDataW = 24;
  localparam int SecW     = 40;
  localparam int CntW     = 16;
  localparam int ReadW    = 17;
  localparam int DayW     = 24;
  localparam int SpentW   = 20;
  localparam int ManW     = 8;
  localparam int CfgW     = 16;
  localparam int RemW     = 22;

  typedef enum logic [1:0] {
    MODE_DAY    = 2'd0,
    MODE_ALLOW  = 2'd1,
    MODE_RECORD = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RSN_NONE     = 2'd0,
    RSN_MANUAL   = 2'd1,
    RSN_DAILY    = 2'd2,
    RSN_RESERVED = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    REG_DAILY_LIMIT  = 2'd0,
    REG_AUTO_RESERVE = 2'd1,
    REG_MANUAL_LIMIT = 2'd2,
    REG_PER_WAKE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t                    mode;
    logic                     is_auto;
    logic [CntW-1:0]          wanted;
    logic [CntW-1:0]          used;
    logic signed [ReadW-1:0]  api_reading;
  } item_t;

  typedef struct packed {
    logic            rolled;
    reason_t         reason;
    logic            blocked;
    logic [CntW-1:0] granted;
  } res_t;

  // floor(t / 86400) = floor(floor(t / 128) / 675)
  localparam longint unsigned DivD   = 675;
  localparam longint unsigned DayK   = ((64'd1 << 32) + DivD - 1) / DivD;
  localparam longint unsigned DayOff = DayK * DivD;
  localparam longint unsigned Recip1 = ((64'd1 << 27) + DivD - 1) / DivD;
  localparam longint unsigned Recip2 = ((64'd1 << 37) + DivD - 1) / DivD;

  localparam logic [CntW-1:0]         LimitRst   = 16'd100;
  localparam logic [CntW-1:0]         ReserveRst = 16'd0;
  localparam logic [ManW-1:0]         ManLimRst  = 8'd255;
  localparam logic [CntW-1:0]         WakeRst    = 16'hFFFF;
  localparam logic signed [DayW-1:0]  DayNever   = 24'sh800000;
  localparam logic signed [ReadW-1:0] SrvUnknown = -17'sd1;
  localparam logic [SpentW-1:0]       SpentMax   = 20'hFFFFF;
  localparam logic [ManW-1:0]         ManMax     = 8'hFF;

endpackage

// File: rtl/drbg_day_div.sv
// Pipelined floor division of signed UTC seconds by 86400 into a day number.
// Four stages, reciprocal multiplies split over two 17/27-bit digits.
// Depends on drbg_pkg.
module drbg_day_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [drbg_pkg::SecW-1:0] in_secs,
  input  drbg_pkg::item_t                  in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [drbg_pkg::DayW-1:0] out_day,
  output drbg_pkg::item_t                  out_item
);
  import drbg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  item_t it1_r, it2_r, it3_r, it4_r;

  logic [33:0] u1_r, u_nxt;
  logic [34:0] p2_r, p2_nxt;
  logic [16:0] uh2_r, ul2_r, ul3_r;
  logic [6:0]  qh3_r, qh4_r, qh;
  logic [9:0]  rh3_r, rh_nxt;
  logic [16:0] qh_mul;
  logic [54:0] p4_r, p4_nxt;
  logic [17:0] m1;
  logic [27:0] m2;
  logic [26:0] x2;
  logic [16:0] q2;
  logic [DayW-1:0] day_u;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign m1 = 18'(Recip1);
  assign m2 = 28'(Recip2);

  // shift out 128, offset by a multiple of 675 to make the value non-negative
  assign u_nxt  = {in_secs[SecW-1], in_secs[SecW-1:7]} + 34'(DayOff);
  assign p2_nxt = {18'd0, u1_r[33:17]} * {17'd0, m1};
  assign qh     = p2_r[33:27];
  assign qh_mul = 17'({10'd0, qh} * 17'(DivD));
  assign rh_nxt = 10'(uh2_r - qh_mul);
  assign x2     = {rh3_r, ul3_r};
  assign p4_nxt = {28'd0, x2} * {27'd0, m2};
  assign q2     = p4_r[53:37];
  assign day_u  = {qh4_r, q2} - DayW'(DayK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1_r <= in_item;
      u1_r  <= u_nxt;
    end
    if (en2) begin
      it2_r <= it1_r;
      p2_r  <= p2_nxt;
      uh2_r <= u1_r[33:17];
      ul2_r <= u1_r[16:0];
    end
    if (en3) begin
      it3_r <= it2_r;
      qh3_r <= qh;
      rh3_r <= rh_nxt;
      ul3_r <= ul2_r;
    end
    if (en4) begin
      it4_r <= it3_r;
      qh4_r <= qh3_r;
      p4_r  <= p4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = it4_r;
  assign out_day   = signed'(day_u);

endmodule

// File: rtl/daily_request_budget_guard.sv
// Daily request budget guard: day rollover, allow query and usage record.
// Accepts one word per cycle while the output is not stalled by out_tready.
// Each word passes through the 4-stage day-number divider, then the result register.
// Stages stall independently, so bubbles fill while a result waits.
// Reset (rst_n, synchronous, active low) clears valids, loads register
// defaults and sets the day to "never", counters to 0, server count to unknown.
module daily_request_budget_guard (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_seconds[39:0], is_automatic[40], wanted[56:41], used[72:57],
  // api_reading[89:73], zero fill above
  input  logic [drbg_pkg::InDataW-1:0]        in_tdata,
  // mode[1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // granted[15:0], blocked[16], block_reason[18:17], day_rolled[19], zero fill
  output logic [drbg_pkg::OutDataW-1:0]       out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [drbg_pkg::CfgW-1:0]           cfg_data
);
  import drbg_pkg::*;

  item_t                    in_item, d_item;
  logic signed [SecW-1:0]   in_secs;
  logic                     d_valid, en_out, fire, roll;
  logic signed [DayW-1:0]   d_day;

  logic [CntW-1:0]          limit_r, auto_res_r, per_wake_r;
  logic [ManW-1:0]          man_lim_r;

  logic signed [DayW-1:0]   cur_day_r, cur_day_nxt;
  logic [SpentW-1:0]        spent_r, spent_nxt;
  logic [ManW-1:0]          man_cnt_r, man_cnt_nxt;
  logic                     auto_ran_r, auto_ran_nxt;
  logic signed [ReadW-1:0]  srv_r, srv_nxt;

  logic                     out_vld_r;
  res_t                     out_res_r, res_nxt;

  logic [CntW-1:0]          reserve, g1, g2;
  logic signed [RemW-1:0]   rem_loc, rem_srv, rem;
  logic [SpentW:0]          spent_sum;

  assign in_secs             = signed'(in_tdata[39:0]);
  assign in_item.mode        = mode_t'(in_tuser);
  assign in_item.is_auto     = in_tdata[40];
  assign in_item.wanted      = in_tdata[56:41];
  assign in_item.used        = in_tdata[72:57];
  assign in_item.api_reading = signed'(in_tdata[89:73]);

  drbg_day_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_secs   (in_secs),
    .in_item   (in_item),
    .out_valid (d_valid),
    .out_ready (en_out),
    .out_day   (d_day),
    .out_item  (d_item)
  );

  assign en_out = !out_vld_r || out_tready;
  assign fire   = d_valid && en_out;

  // allow-query arithmetic
  assign reserve   = (d_item.is_auto || auto_ran_r) ? '0 : auto_res_r;
  assign rem_loc   = signed'({6'd0, limit_r}) - signed'({2'd0, spent_r})
                   - signed'({6'd0, reserve});
  assign rem_srv   = signed'({6'd0, srv_r[ReadW-2:0]}) - signed'({6'd0, reserve});
  assign rem       = (!srv_r[ReadW-1] && (rem_srv < rem_loc)) ? rem_srv : rem_loc;
  assign g1        = (d_item.wanted < rem[CntW-1:0]) ? d_item.wanted : rem[CntW-1:0];
  assign g2        = (g1 < per_wake_r) ? g1 : per_wake_r;
  assign spent_sum = {1'b0, spent_r} + {5'd0, d_item.used};

  always_comb begin
    res_nxt      = '0;
    roll         = 1'b0;
    cur_day_nxt  = cur_day_r;
    spent_nxt    = spent_r;
    man_cnt_nxt  = man_cnt_r;
    auto_ran_nxt = auto_ran_r;
    srv_nxt      = srv_r;
    unique case (d_item.mode)
      MODE_DAY: begin
        if (d_day != cur_day_r) begin
          roll         = 1'b1;
          cur_day_nxt  = d_day;
          spent_nxt    = '0;
          man_cnt_nxt  = '0;
          auto_ran_nxt = 1'b0;
          srv_nxt      = SrvUnknown;
        end
        res_nxt.rolled = roll;
      end
      MODE_ALLOW: begin
        if (d_item.wanted != '0) begin
          if (!d_item.is_auto && (man_cnt_r >= man_lim_r)) begin
            res_nxt.blocked = 1'b1;
            res_nxt.reason  = RSN_MANUAL;
          end else if (rem[RemW-1] || (rem == '0)) begin
            res_nxt.blocked = 1'b1;
            res_nxt.reason  = d_item.is_auto ? RSN_DAILY : RSN_RESERVED;
          end else begin
            res_nxt.granted = g2;
          end
        end
      end
      MODE_RECORD: begin
        spent_nxt = spent_sum[SpentW] ? SpentMax : spent_sum[SpentW-1:0];
        if (d_item.is_auto) begin
          auto_ran_nxt = 1'b1;
        end else if ((d_item.used != '0) && (man_cnt_r != ManMax)) begin
          man_cnt_nxt = man_cnt_r + ManW'(1);
        end
        if (!d_item.api_reading[ReadW-1]) srv_nxt = d_item.api_reading;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r  <= DayNever;
      spent_r    <= '0;
      man_cnt_r  <= '0;
      auto_ran_r <= 1'b0;
      srv_r      <= SrvUnknown;
      out_vld_r  <= 1'b0;
    end else begin
      if (fire) begin
        cur_day_r  <= cur_day_nxt;
        spent_r    <= spent_nxt;
        man_cnt_r  <= man_cnt_nxt;
        auto_ran_r <= auto_ran_nxt;
        srv_r      <= srv_nxt;
      end
      if (en_out) out_vld_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) out_res_r <= res_nxt;
  end

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LimitRst;
      auto_res_r <= ReserveRst;
      man_lim_r  <= ManLimRst;
      per_wake_r <= WakeRst;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DAILY_LIMIT:  limit_r    <= cfg_data;
        REG_AUTO_RESERVE: auto_res_r <= cfg_data;
        REG_MANUAL_LIMIT: man_lim_r  <= cfg_data[ManW-1:0];
        REG_PER_WAKE:     per_wake_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OutDataW - $bits(res_t))'(0), out_res_r};

  // assertions
  a_block_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.blocked == (out_res_r.reason != RSN_NONE)))
    else $error("blocked flag and reason disagree");

  a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.blocked) |-> (out_res_r.granted == '0))
    else $error("blocked word carries a grant");

  a_roll_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && roll) |=> (spent_r == '0 && man_cnt_r == '0 && !auto_ran_r
                        && srv_r == SrvUnknown))
    else $error("day rollover did not clear state");

  a_spent_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(fire && roll)) |-> (spent_r >= $past(spent_r)))
    else $error("spent count decreased without rollover");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Stream testbench for daily_request_budget_guard: directed table, then random days of
// allow/record traffic under several limit settings, checked word by word against a
// built-in budget model. Depends on drbg_pkg and the guard RTL only.
module testbench;
  import drbg_pkg::*;

  typedef struct packed {
    mode_t              mode;
    logic signed [39:0] secs;
    logic               is_auto;
    logic [15:0]        wanted;
    logic [15:0]        used;
    logic signed [16:0] api;
  } word_t;

  typedef struct {
    bit       is_cfg;
    reg_idx_t idx;
    int       val;
    word_t    w;
    bit       has_exp;
    res_t     exp;
  } row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // shadow limits and per-day state
  logic [15:0]        lim_daily, lim_reserve, lim_wake;
  logic [7:0]         lim_manual;
  logic signed [23:0] day_num;
  logic [19:0]        spent_cnt;
  logic [7:0]         manual_cnt;
  logic               auto_seen;
  logic signed [16:0] srv_left;

  res_t pending_verdicts[$];
  row_t stim_tab[$];
  int   errors = 0;
  int   n_words = 0, n_rolls = 0, n_grants = 0;
  int   n_refused[4] = '{0, 0, 0, 0};
  int   burst_left = 0;
  longint day_hint = 0;

  daily_request_budget_guard i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic res_t budget_step(word_t w);
    res_t   r;
    longint secs, day, reserve, left, g, lim, wake, srv, sum;
    r = '0;
    case (w.mode)
      MODE_DAY: begin
        secs = w.secs;
        day = secs / 86400;
        if (secs < 0 && secs % 86400 != 0) day = day - 1;
        if (day != longint'(day_num)) begin
          day_num = 24'(day);
          spent_cnt = '0;
          manual_cnt = '0;
          auto_seen = 1'b0;
          srv_left = -17'sd1;
          r.rolled = 1'b1;
        end
      end
      MODE_ALLOW: begin
        if (w.wanted != 0) begin
          reserve = 0;
          if (!w.is_auto && !auto_seen) reserve = lim_reserve;
          lim = lim_daily;
          sum = spent_cnt;
          left = lim - sum - reserve;
          if (srv_left >= 0) begin
            srv = srv_left;
            if (srv - reserve < left) left = srv - reserve;
          end
          if (!w.is_auto && manual_cnt >= lim_manual) begin
            r.blocked = 1'b1;
            r.reason = RSN_MANUAL;
          end else if (left <= 0) begin
            r.blocked = 1'b1;
            r.reason = w.is_auto ? RSN_DAILY : RSN_RESERVED;
          end else begin
            g = w.wanted;
            wake = lim_wake;
            if (left < g) g = left;
            if (wake < g) g = wake;
            r.granted = 16'(g);
          end
        end
      end
      MODE_RECORD: begin
        if (w.used != 0) begin
          sum = spent_cnt;
          sum = sum + w.used;
          spent_cnt = (sum > 64'hFFFFF) ? 20'hFFFFF : 20'(sum);
        end
        if (w.is_auto) auto_seen = 1'b1;
        else if (w.used != 0 && manual_cnt != 8'hFF) manual_cnt = manual_cnt + 8'd1;
        if (w.api >= 0) srv_left = w.api;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic word_t word_of(mode_t m, longint secs, int a, int wanted, int used,
                                    int api);
    word_t w;
    w.mode = m;
    w.secs = 40'(secs);
    w.is_auto = 1'(a);
    w.wanted = 16'(wanted);
    w.used = 16'(used);
    w.api = 17'(api);
    return w;
  endfunction

  function automatic word_t noise_word(mode_t m);
    word_t       w;
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    w.mode = m;
    w.secs = r64[39:0];
    w.is_auto = 1'($urandom);
    w.wanted = 16'($urandom);
    w.used = 16'($urandom);
    w.api = 17'($urandom);
    return w;
  endfunction

  function automatic res_t verdict(int g, int b, reason_t rs, int rol);
    res_t v;
    v.granted = 16'(g);
    v.blocked = 1'(b);
    v.reason = rs;
    v.rolled = 1'(rol);
    return v;
  endfunction

  function automatic row_t item_row(word_t w);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_DAILY_LIMIT;
    r.val = 0;
    r.w = w;
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic row_t checked_row(word_t w, res_t e);
    row_t r;
    r = item_row(w);
    r.has_exp = 1'b1;
    r.exp = e;
    return r;
  endfunction

  function automatic row_t cfg_row(reg_idx_t i, int v);
    row_t r;
    r = item_row('0);
    r.is_cfg = 1'b1;
    r.idx = i;
    r.val = v;
    return r;
  endfunction

  function automatic logic [15:0] pick_wanted();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_used();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic logic signed [16:0] pick_reading();
    case ($urandom_range(0, 9))
      5, 6: return 17'($urandom_range(0, 400));
      7: return {1'b0, 16'($urandom)};
      8: return 17'h10000 | 17'($urandom);
      9: return 17'sd0;
      default: return -17'sd1;
    endcase
  endfunction

  task automatic push_word(input word_t w, output res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= w.mode;
    in_tdata <= {6'd0, w.api, w.used, w.wanted, w.is_auto, w.secs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = budget_step(w);
    pending_verdicts.push_back(want);
    n_words++;
    if (want.rolled) n_rolls++;
    if (want.blocked) n_refused[want.reason]++;
    else if (want.granted != 0) n_grants++;
  endtask

  // hold off the sender until the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DAILY_LIMIT:  lim_daily = 16'(val);
      REG_AUTO_RESERVE: lim_reserve = 16'(val);
      REG_MANUAL_LIMIT: lim_manual = 8'(val);
      REG_PER_WAKE:     lim_wake = 16'(val);
      default: ;
    endcase
  endtask

  task automatic apply_limits(input int daily, input int reserve, input int manual,
                              input int wake);
    settle();
    write_reg(REG_DAILY_LIMIT, daily);
    write_reg(REG_AUTO_RESERVE, reserve);
    write_reg(REG_MANUAL_LIMIT, manual);
    write_reg(REG_PER_WAKE, wake);
    cfg_valid <= 1'b0;
  endtask

  // Each day opens with a fresh day check; inside it mostly allow/record pairs (lone records in
  // one long day) that spend part of the grant, mixed with lone records, repeat checks and broken pairs.
  task automatic run_days(input int n_items, input bit one_long_day);
    word_t  w, wr;
    res_t   r;
    int     sent, day_left, k;
    longint day;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 1) != 0) begin
        day = $urandom_range(0, 12_724_000);
        day = day - 6_362_000;
      end else begin
        day = day_hint + $urandom_range(1, 3);
      end
      day_hint = day;
      w = noise_word(MODE_DAY);
      w.secs = 40'(day * 86400 + $urandom_range(0, 86399));
      push_word(w, r);
      sent++;
      day_left = one_long_day ? n_items : $urandom_range(3, 40);
      while (day_left > 0 && sent < n_items) begin
        k = $urandom_range(0, 19);
        if (one_long_day && k < 12) begin
          w = noise_word(MODE_RECORD);
          w.is_auto = ($urandom_range(0, 15) == 0);
          w.used = 16'($urandom_range(1, 65535));
          w.api = pick_reading();
          push_word(w, r);
          sent++;
        end else if (k < 11 || k >= 18) begin
          w = noise_word(MODE_ALLOW);
          w.is_auto = ($urandom_range(0, 4) == 0);
          w.wanted = pick_wanted();
          push_word(w, r);
          wr = noise_word(MODE_RECORD);
          wr.is_auto = w.is_auto;
          if (k >= 18) wr.used = pick_used();
          else if (r.granted != 0) wr.used = 16'($urandom_range(0, r.granted));
          else wr.used = 16'd0;
          wr.api = pick_reading();
          push_word(wr, r);
          sent += 2;
        end else if (k < 14) begin
          w = noise_word(MODE_RECORD);
          w.used = pick_used();
          w.api = pick_reading();
          push_word(w, r);
          sent++;
        end else if (k < 16 || (k == 16 && one_long_day)) begin
          w = noise_word(MODE_DAY);
          w.secs = 40'(day * 86400 + $urandom_range(0, 86399));
          push_word(w, r);
          sent++;
        end else if (k == 16) begin
          push_word(noise_word(MODE_DAY), r);
          sent++;
        end else begin
          w = noise_word(MODE_ALLOW);
          w.wanted = pick_wanted();
          push_word(w, r);
          sent++;
        end
        day_left--;
        if ($urandom_range(0, 299) == 0) settle();
      end
    end
  endtask

  always @(posedge clk) begin : rx_check
    res_t              got, want;
    static rx_style_t  style = RX_OPEN;
    static int         style_left = 0;
    static logic [31:0] cyc = '0;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[19:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result word %h with nothing expected", out_tdata);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, got.granted);
          errors++;
        end
        if (got.blocked !== want.blocked) begin
          $error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
          errors++;
        end
        if (got.reason !== want.reason) begin
          $error("block_reason: expected %0d, got %0d", want.reason, got.reason);
          errors++;
        end
        if (got.rolled !== want.rolled) begin
          $error("day_rolled: expected %0d, got %0d", want.rolled, got.rolled);
          errors++;
        end
      end
    end
    cyc = cyc + 1;
    if (style_left == 0) begin
      style = rx_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(8, 120);
    end else begin
      style_left--;
    end
    case (style)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom);
      RX_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
      default:   out_tready <= cyc[2];
    endcase
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    res_t r;
    bit   cfg_open;
    lim_daily = LimitRst;
    lim_reserve = ReserveRst;
    lim_manual = ManLimRst;
    lim_wake = WakeRst;
    day_num = DayNever;
    spent_cnt = '0;
    manual_cnt = '0;
    auto_seen = 1'b0;
    srv_left = SrvUnknown;
    cfg_open = 1'b0;

    stim_tab.push_back(checked_row(word_of(MODE_DAY, 0, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, 86399, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, -1, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, -86400, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, 64'sd549755813887, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, -64'sd549755813888, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 1, 65535, 0, 0),
                                   verdict(100, 0, RSN_NONE, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_RECORD, 0, 1, 0, 65535, 65535),
                                   verdict(0, 0, RSN_NONE, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 0, 1, 0, 0),
                                   verdict(0, 1, RSN_RESERVED, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 1, 5, 0, 0),
                                   verdict(0, 1, RSN_DAILY, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, 172800, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_RECORD, 0, 0, 0, 10, -1),
                                   verdict(0, 0, RSN_NONE, 0)));
    stim_tab.push_back(item_row(word_of(MODE_RECORD, 0, 0, 0, 0, 30)));
    stim_tab.push_back(item_row(word_of(MODE_ALLOW, 0, 0, 50, 0, 0)));
    stim_tab.push_back(item_row(word_of(MODE_RECORD, 0, 0, 0, 65535, -65536)));
    stim_tab.push_back(cfg_row(REG_MANUAL_LIMIT, 0));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 0, 1, 0, 0),
                                   verdict(0, 1, RSN_MANUAL, 0)));
    stim_tab.push_back(item_row(word_of(MODE_ALLOW, 0, 1, 65535, 0, 0)));
    stim_tab.push_back(cfg_row(REG_AUTO_RESERVE, 65535));
    stim_tab.push_back(cfg_row(REG_DAILY_LIMIT, 65535));
    stim_tab.push_back(cfg_row(REG_PER_WAKE, 1));
    stim_tab.push_back(cfg_row(REG_MANUAL_LIMIT, 255));
    stim_tab.push_back(checked_row(word_of(MODE_DAY, 259200, 0, 0, 0, 0),
                                   verdict(0, 0, RSN_NONE, 1)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 0, 65535, 0, 0),
                                   verdict(0, 1, RSN_RESERVED, 0)));
    stim_tab.push_back(checked_row(word_of(MODE_ALLOW, 0, 1, 65535, 0, 0),
                                   verdict(1, 0, RSN_NONE, 0)));
    stim_tab.push_back(item_row(word_of(MODE_RECORD, 0, 1, 0, 1, 0)));
    stim_tab.push_back(item_row(word_of(MODE_ALLOW, 0, 0, 5, 0, 0)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[k]) begin
      if (stim_tab[k].is_cfg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(stim_tab[k].idx, stim_tab[k].val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        push_word(stim_tab[k].w, r);
        if (stim_tab[k].has_exp)
          pending_verdicts[pending_verdicts.size() - 1] = stim_tab[k].exp;
      end
    end

    apply_limits(100, 0, 255, 65535);
    run_days(260, 1'b0);
    apply_limits(0, 0, 0, 0);
    run_days(120, 1'b0);
    apply_limits(65535, 65535, 255, 65535);
    run_days(150, 1'b0);
    // one long day drives the spent and manual counters into saturation
    apply_limits(65535, 0, 255, 65535);
    run_days(400, 1'b1);
    repeat (3) begin
      apply_limits($urandom_range(0, 600), $urandom_range(0, 200), $urandom_range(0, 12),
                   $urandom_range(1, 250));
      run_days(160, 1'b0);
    end
    settle();

    $display("summary: %0d words, %0d day rollovers, %0d nonzero grants", n_words, n_rolls,
             n_grants);
    $display("summary: refusals manual %0d, daily %0d, reserve %0d, over 10 limit settings",
             n_refused[RSN_MANUAL], n_refused[RSN_DAILY], n_refused[RSN_RESERVED]);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/drbg_pkg.sv
rtl/drbg_day_div.sv
rtl/daily_request_budget_guard.sv
test/testbench.sv
